@@ rtl/core/tws_pkg.sv @@
`default_nettype none

package tws_pkg;

	// vector geometry
	localparam int MAX_TOPICS = 64;
	localparam int IDX_W      = $clog2(MAX_TOPICS);
	localparam int CNT_W      = IDX_W + 1;

	// fixed point: 65536 is 1.0
	localparam int WEIGHT_W = 17;
	localparam logic [WEIGHT_W-1:0] ONE_FIX = WEIGHT_W'(65536);

	// vector total and divider remainder
	localparam int TOTAL_W = WEIGHT_W + IDX_W;
	localparam int REM_W   = TOTAL_W + 1;
	localparam int FRAC_W  = 16;
	localparam int STEP_W  = $clog2(FRAC_W + 1);

	// topic_count register
	localparam int CFG_W = 7;
	localparam logic [CFG_W-1:0] TOPIC_RESET = CFG_W'(8);

	// floor(n/6) as (n*43)>>8, exact for n up to 64
	localparam int RECIP6     = 43;
	localparam int RECIP6_SH  = 8;
	localparam int THR_PROD_W = CNT_W + 6;

	// sequencer states
	typedef enum logic [2:0] {
		ST_FILL,
		ST_EVAL,
		ST_READ,
		ST_LOAD,
		ST_DIV,
		ST_EMIT
	} tws_state_t;

endpackage

`default_nettype wire

@@ rtl/core/topic_weight_sparsify.sv @@
`default_nettype none

// Channel   Dir  Handshake              Payload
// in        in   in_valid / in_stall    weight[16:0]
// out       out  out_valid / out_stall  weight_out[16:0] topic_index[5:0] was_refined last
// cfg       in   cfg_valid / cfg_ready  cfg_data[6:0] (topic_count)
//
// Gathering takes one weight per cycle while in_valid is high; the full vector is then evaluated.
// Each result passes through read, load and emit; a refined result with a nonzero sum also
// runs 16 steps of the bit-serial restoring divider that forms floor(w*65536/sum) before emit.
// No weight is taken while a vector is being emitted; results leave through an output register.
// Reset clears the vector counters and sets topic_count to 8; the weight store is not cleared.
// out_stall holds the output register and keeps the sequencer waiting to emit; cfg_ready is high.
module topic_weight_sparsify
	import tws_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	// input words
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [WEIGHT_W-1:0] weight,
	// result words
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [WEIGHT_W-1:0]      weight_out,
	output logic [IDX_W-1:0]         topic_index,
	output logic                     was_refined,
	output logic                     last,
	// configuration
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [CFG_W-1:0]    cfg_data
);

	tws_state_t state_q, state_d;

	logic [CFG_W-1:0]    cfg_q;
	logic [CNT_W-1:0]    n_eff;
	logic [THR_PROD_W-1:0] thr_prod;
	logic [CNT_W-1:0]    thr;

	logic [CNT_W-1:0]    fill_q;
	logic [CNT_W-1:0]    below_q;
	logic [WEIGHT_W-1:0] small_val_q;
	logic [CNT_W-1:0]    small_pos_q;
	logic [TOTAL_W-1:0]  total_q;

	logic                refine_q;
	logic [TOTAL_W-1:0]  sum_q;
	logic [IDX_W-1:0]    k_q;
	logic [REM_W-1:0]    rem_q;
	logic [WEIGHT_W-1:0] quo_q;
	logic [STEP_W-1:0]   step_q;

	logic [WEIGHT_W-1:0] mem [MAX_TOPICS];
	logic [WEIGHT_W-1:0] rd_data_q;

	logic                out_valid_q;
	logic [WEIGHT_W-1:0] weight_out_q;
	logic [IDX_W-1:0]    topic_index_q;
	logic                was_refined_q;
	logic                last_q;

	logic                in_acc, cfg_acc, out_free;
	logic [WEIGHT_W-1:0] w_sat;
	logic [WEIGHT_W+CNT_W-1:0] w_prod;
	logic                w_below, w_small;
	logic [CNT_W-1:0]    fill_inc;
	logic                refine_c;
	logic                k_last;
	logic                k_zeroed;
	logic [WEIGHT_W-1:0] v_load;
	logic                v_ge_sum;
	logic [REM_W-1:0]    v_ext, sum_ext, rem_sh;
	logic                rem_ge;

	// handshakes
	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid & cfg_ready;
	assign in_stall  = (state_q != ST_FILL);
	assign in_acc    = in_valid & ~in_stall;
	assign out_free  = ~out_valid_q | ~out_stall;

	// effective count and sparsity threshold
	always_comb begin
		if (cfg_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (cfg_q > CFG_W'(MAX_TOPICS)) begin
			n_eff = CNT_W'(MAX_TOPICS);
		end else begin
			n_eff = CNT_W'(cfg_q);
		end
		thr_prod = THR_PROD_W'(n_eff) * THR_PROD_W'(RECIP6);
		thr      = CNT_W'(thr_prod >> RECIP6_SH);
	end

	// incoming weight: saturate and classify
	assign w_sat    = (weight > ONE_FIX) ? ONE_FIX : weight;
	assign w_prod   = (WEIGHT_W+CNT_W)'(w_sat) * (WEIGHT_W+CNT_W)'(n_eff);
	assign w_below  = w_prod < (WEIGHT_W+CNT_W)'(ONE_FIX);
	assign w_small  = w_below && (w_sat != '0) && (w_sat < small_val_q);
	assign fill_inc = fill_q + CNT_W'(1);

	// vector decision
	assign refine_c = (below_q > thr) && (small_pos_q < n_eff);

	// emission helpers
	assign k_last   = ({1'b0, k_q} == (n_eff - CNT_W'(1)));
	assign k_zeroed = refine_q && ({1'b0, k_q} == small_pos_q);
	assign v_load   = k_zeroed ? '0 : rd_data_q;
	assign v_ext    = REM_W'(v_load);
	assign sum_ext  = REM_W'(sum_q);
	assign v_ge_sum = v_ext >= sum_ext;
	assign rem_sh   = {rem_q[REM_W-2:0], 1'b0};
	assign rem_ge   = rem_sh >= sum_ext;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_FILL: begin
				if (in_acc && fill_inc >= n_eff) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				state_d = ST_READ;
			end
			ST_READ: begin
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				if (!refine_q || sum_q == '0) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (step_q == STEP_W'(1)) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = k_last ? ST_FILL : ST_READ;
				end
			end
			default: begin
				state_d = ST_FILL;
			end
		endcase
		if (cfg_acc) begin
			state_d = ST_FILL;
		end
	end

	// configuration and gathering counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q       <= TOPIC_RESET;
			fill_q      <= '0;
			below_q     <= '0;
			small_val_q <= ONE_FIX;
			small_pos_q <= CNT_W'(MAX_TOPICS);
			total_q     <= '0;
		end else if (cfg_acc) begin
			cfg_q       <= cfg_data;
			fill_q      <= '0;
			below_q     <= '0;
			small_val_q <= ONE_FIX;
			small_pos_q <= CNT_W'(MAX_TOPICS);
			total_q     <= '0;
		end else if (in_acc) begin
			fill_q  <= fill_inc;
			total_q <= total_q + TOTAL_W'(w_sat);
			if (w_below) begin
				below_q <= below_q + CNT_W'(1);
			end
			if (w_small) begin
				small_val_q <= w_sat;
				small_pos_q <= fill_q;
			end
		end else if (state_q == ST_EMIT && out_free && k_last) begin
			fill_q      <= '0;
			below_q     <= '0;
			small_val_q <= ONE_FIX;
			small_pos_q <= CNT_W'(MAX_TOPICS);
			total_q     <= '0;
		end
	end

	// weight store
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mem[fill_q[IDX_W-1:0]] <= w_sat;
		end
		rd_data_q <= mem[k_q];
	end

	// emission control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refine_q <= 1'b0;
			k_q      <= '0;
		end else if (state_q == ST_EVAL) begin
			refine_q <= refine_c;
			k_q      <= '0;
		end else if (state_q == ST_EMIT && out_free && !k_last) begin
			k_q <= k_q + IDX_W'(1);
		end
	end

	// remaining sum, taken once per vector
	always_ff @(posedge clk) begin
		if (state_q == ST_EVAL) begin
			sum_q <= refine_c ? (total_q - TOTAL_W'(small_val_q)) : total_q;
		end
	end

	// bit-serial restoring divider; quotient never exceeds 65536 since w <= sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (state_q == ST_LOAD) begin
			step_q <= STEP_W'(FRAC_W);
		end else if (state_q == ST_DIV) begin
			step_q <= step_q - STEP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			if (!refine_q) begin
				quo_q <= v_load;
			end else if (sum_q == '0) begin
				quo_q <= '0;
			end else begin
				quo_q <= WEIGHT_W'(v_ge_sum);
				rem_q <= v_ge_sum ? (v_ext - sum_ext) : v_ext;
			end
		end else if (state_q == ST_DIV) begin
			quo_q <= {quo_q[WEIGHT_W-2:0], rem_ge};
			rem_q <= rem_ge ? (rem_sh - sum_ext) : rem_sh;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			weight_out_q  <= quo_q;
			topic_index_q <= k_q;
			was_refined_q <= refine_q;
			last_q        <= k_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign weight_out  = weight_out_q;
	assign topic_index = topic_index_q;
	assign was_refined = was_refined_q;
	assign last        = last_q;

	// checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FILL |-> fill_q < n_eff)
		else $error("fill position past vector length");

	a_eval_full: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EVAL |-> fill_q == n_eff)
		else $error("evaluation started on a partial vector");

	a_div_only_refined: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> refine_q && sum_q != '0)
		else $error("divider running without a refined nonzero sum");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> rem_q < sum_ext)
		else $error("divider remainder not below divisor");

	a_quo_sat: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> quo_q <= ONE_FIX)
		else $error("result above one");

endmodule

`default_nettype wire

@@ tb/topic_weight_sparsify_tb.sv @@
`timescale 1ns / 1ps

module topic_weight_sparsify_tb;
	import tws_pkg::*;

	localparam int CLK_HALF       = 6;
	localparam int RESET_CYCLES   = 7;
	localparam int TARGET_WEIGHTS = 400;
	localparam int HOLD_CYCLES    = 300;
	// idle time after the last result before a count write or the verdict
	localparam int SETTLE_CYCLES  = 48;
	localparam longint unsigned RUN_LIMIT_NS = 5_000_000;

	// opening words, all under the reset count of 8
	localparam logic [WEIGHT_W-1:0] OPENING [26] = '{
		// saturated inputs, threshold edge 8192/8191, two equal smallest: first wins
		17'd0, 17'd131071, 17'd65536, 17'd8192, 17'd8191, 17'd1, 17'd1, 17'd0,
		// all zero: many below but none positive, so no refinement
		17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0,
		// only positive weight is zeroed, remaining sum is zero
		17'd0, 17'd0, 17'd0, 17'd5, 17'd0, 17'd0, 17'd0, 17'd0,
		// partial vector, dropped by the next count write
		17'd65536, 17'd3
	};

	// one result word
	typedef struct packed {
		logic [WEIGHT_W-1:0] weight;
		logic [IDX_W-1:0]    index;
		logic                refined;
		logic                last;
	} topic_word_t;

	// vector predictor and queue of result words still to come
	class sparsify_scoreboard;
		logic [CFG_W-1:0]    topic_count;
		logic [WEIGHT_W-1:0] stored [MAX_TOPICS];
		int unsigned         fill;
		int unsigned         below;
		logic [WEIGHT_W-1:0] smallest;
		int unsigned         smallest_at;
		longint unsigned     total;
		topic_word_t         upcoming [$];
		int unsigned         errors;

		function new();
			topic_count = TOPIC_RESET;
			errors = 0;
			restart_vector();
		endfunction

		static function int unsigned topics_in_use(input logic [CFG_W-1:0] c);
			if (c == 0) return 1;
			if (c > MAX_TOPICS) return MAX_TOPICS;
			return c;
		endfunction

		function void restart_vector();
			fill = 0;
			below = 0;
			smallest = ONE_FIX;
			smallest_at = MAX_TOPICS;
			total = 0;
		endfunction

		function void set_count(input logic [CFG_W-1:0] value);
			topic_count = value;
			restart_vector();
		endfunction

		function int unsigned pending();
			return upcoming.size();
		endfunction

		function void note_weight(input logic [WEIGHT_W-1:0] raw);
			int unsigned n;
			logic [WEIGHT_W-1:0] w;
			bit refine;
			longint unsigned sum;
			longint unsigned v;
			topic_word_t word;
			n = topics_in_use(topic_count);
			w = (raw > ONE_FIX) ? ONE_FIX : raw;
			stored[fill] = w;
			total += w;
			// below 1/n, tested exactly
			if (w * n < 32'd65536) begin
				below++;
				if (w != 0 && w < smallest) begin
					smallest = w;
					smallest_at = fill;
				end
			end
			fill++;
			if (fill < n) return;
			// vector complete: decide, renormalize when refined, queue every weight
			refine = (below > n / 6) && (smallest_at < n);
			sum = total;
			if (refine) begin
				sum -= stored[smallest_at];
				stored[smallest_at] = '0;
			end
			for (int unsigned k = 0; k < n; k++) begin
				v = stored[k];
				if (refine) begin
					if (sum == 0) begin
						v = 0;
					end else begin
						v = (v << 16) / sum;
						if (v > 65536) v = 65536;
					end
				end
				word.weight  = v[WEIGHT_W-1:0];
				word.index   = k[IDX_W-1:0];
				word.refined = refine;
				word.last    = (k + 1 == n);
				upcoming.insert(upcoming.size(), word);
			end
			restart_vector();
		endfunction

		// fields shown as weight/index/refined/last
		function void check_result(input topic_word_t got);
			topic_word_t want;
			if (upcoming.size() == 0) begin
				$display("%0t: unexpected word %0d/%0d/%0b/%0b", $time,
					got.weight, got.index, got.refined, got.last);
				errors++;
				return;
			end
			want = upcoming.pop_front();
			if (got !== want) begin
				$display("%0t: mismatch expected %0d/%0d/%0b/%0b actual %0d/%0d/%0b/%0b",
					$time, want.weight, want.index, want.refined, want.last,
					got.weight, got.index, got.refined, got.last);
				errors++;
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [WEIGHT_W-1:0] weight;
	logic                out_valid;
	logic                out_stall;
	logic [WEIGHT_W-1:0] weight_out;
	logic [IDX_W-1:0]    topic_index;
	logic                was_refined;
	logic                last;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CFG_W-1:0]    cfg_data;

	sparsify_scoreboard sb = new();
	bit          quiet;
	bit          hold_req;
	int unsigned words_sent;

	topic_weight_sparsify dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.weight      (weight),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.weight_out  (weight_out),
		.topic_index (topic_index),
		.was_refined (was_refined),
		.last        (last),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// gap length: mostly none or short, now and then long
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// weights biased below 1/n so that vectors get refined
	function automatic logic [WEIGHT_W-1:0] pick_weight(input int unsigned n);
		int unsigned below_max;
		int unsigned r;
		below_max = 65535 / n;
		r = $urandom_range(0, 19);
		if (r < 9) return WEIGHT_W'($urandom_range(1, below_max));
		if (r == 9) return WEIGHT_W'(below_max);
		if (r == 10) return WEIGHT_W'(below_max + 1);
		if (r == 11) return '0;
		if (r < 16) return WEIGHT_W'($urandom_range(0, 65536));
		if (r == 16) return ONE_FIX;
		if (r < 19) return WEIGHT_W'($urandom_range(65537, 131071));
		return WEIGHT_W'($urandom);
	endfunction

	// offer one weight word after an optional gap, wait for acceptance
	task automatic send_weight(input logic [WEIGHT_W-1:0] value, input int unsigned gap);
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		weight <= value;
		do @(posedge clk); while (in_stall);
		sb.note_weight(value);
		words_sent++;
	endtask

	// stop offering, wait for every result, then let the block settle
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_count(input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		sb.set_count(value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// one setting of topic_count with a run of random weights
	task automatic run_phase(input logic [CFG_W-1:0] cnt, input int unsigned items,
			input bit calm, input bit hold);
		int unsigned n;
		n = sparsify_scoreboard::topics_in_use(cnt);
		drain();
		write_count(cnt);
		quiet = calm;
		hold_req = hold;
		repeat (items) send_weight(pick_weight(n), pick_gap());
		quiet = 1'b0;
	endtask

	// receiver stall pattern, with one long hold on request
	initial begin
		int unsigned stall_left;
		out_stall = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				out_stall <= 1'b0;
				hold_req = 1'b0;
			end else if (stall_left != 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
			end
		end
	end

	// result check
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result({weight_out, topic_index, was_refined, last});
	end

	// run limit
	initial begin
		#RUN_LIMIT_NS;
		$display("FAILURE");
		$finish;
	end

	// stimulus and verdict
	initial begin
		logic [CFG_W-1:0] cnt;
		arst_n = 1'b0;
		in_valid = 1'b0;
		weight = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		quiet = 1'b0;
		hold_req = 1'b0;
		words_sent = 0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		foreach (OPENING[i]) send_weight(OPENING[i], pick_gap());

		// count 0 acts as one topic
		run_phase(7'd0, 12, 1'b0, 1'b0);
		// above the maximum acts as 64; receiver holds while the sender keeps offering
		run_phase(7'd127, MAX_TOPICS + 10, 1'b1, 1'b1);
		// a stretch with no idling
		run_phase(7'd1, 12, 1'b1, 1'b0);
		run_phase(7'd64, MAX_TOPICS, 1'b0, 1'b0);
		run_phase(7'd6, 24, 1'b0, 1'b0);

		while (words_sent < TARGET_WEIGHTS) begin
			if ($urandom_range(0, 7) == 0) cnt = CFG_W'($urandom_range(13, 40));
			else cnt = CFG_W'($urandom_range(1, 12));
			run_phase(cnt, $urandom_range(8, 40), $urandom_range(0, 5) == 0, 1'b0);
		end

		drain();
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/tws_pkg.sv
rtl/core/topic_weight_sparsify.sv
tb/topic_weight_sparsify_tb.sv
